### sv/assert_macros.svh
// Assertion macros used by the scheduler top level to check its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define NPS_ASSERT(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NPS_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/nps_pkg.sv
// Types and constants of the nonpreemptive priority scheduler.
`default_nettype none
package nps_pkg;

	localparam int ARR_W   = 16;
	localparam int BURST_W = 16;
	localparam int PRIO_W  = 8;
	localparam int ID_W    = 6;
	localparam int TIME_W  = 23;
	localparam int SUM_W   = 29;

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
	localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};

	// One stored process record.
	typedef struct packed {
		logic [ARR_W-1:0]   arrival;
		logic [BURST_W-1:0] burst;
		logic [PRIO_W-1:0]  prio;
	} rec_t;

	// Control from the sequencer to the selection unit.
	typedef struct packed {
		logic              start;
		logic              vld;
		logic              fin;
		logic [ID_W-1:0]   idx;
		rec_t              rec;
		logic [TIME_W-1:0] now;
	} scan_ctl_t;

	// Outcome of one scan over the record memory.
	typedef struct packed {
		logic             has_pick;
		logic [ID_W-1:0]  pick_idx;
		rec_t             pick;
		logic [ARR_W-1:0] next_arr;
	} scan_st_t;

endpackage
`default_nettype wire

### sv/nps_ifs.sv
// Record and result channel interfaces of the scheduler.
`default_nettype none
interface nps_rec_if;
	logic                          valid;
	logic                          ready;
	logic [nps_pkg::ARR_W-1:0]     arrival_time;
	logic [nps_pkg::BURST_W-1:0]   burst_time;
	logic [nps_pkg::PRIO_W-1:0]    priority_level;
	logic                          last_record;

	modport source (output valid, arrival_time, burst_time, priority_level, last_record,
		input ready);
	modport sink (input valid, arrival_time, burst_time, priority_level, last_record,
		output ready);
endinterface

interface nps_res_if;
	logic                          valid;
	logic                          ready;
	logic [nps_pkg::ID_W-1:0]      process_id;
	logic [nps_pkg::TIME_W-1:0]    completion_time;
	logic [nps_pkg::TIME_W-1:0]    turnaround_time;
	logic [nps_pkg::TIME_W-1:0]    waiting_time;
	logic [nps_pkg::SUM_W-1:0]     total_turnaround;
	logic [nps_pkg::SUM_W-1:0]     total_waiting;
	logic                          last_result;

	modport source (output valid, process_id, completion_time, turnaround_time,
		waiting_time, total_turnaround, total_waiting, last_result, input ready);
	modport sink (input valid, process_id, completion_time, turnaround_time,
		waiting_time, total_turnaround, total_waiting, last_result, output ready);
endinterface
`default_nettype wire

### sv/nps_scan.sv
// Selection unit: tracks the best ready record and the next arrival over one scan.
`default_nettype none
module nps_scan (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire nps_pkg::scan_ctl_t ctl,
	output nps_pkg::scan_st_t       st
);

	logic                          has_q;
	logic [nps_pkg::ID_W-1:0]      idx_q;
	nps_pkg::rec_t                 best_q;
	logic [nps_pkg::ARR_W-1:0]     next_q;
	logic                          ready_now;
	logic                          better;

	assign ready_now = {{(nps_pkg::TIME_W-nps_pkg::ARR_W){1'b0}}, ctl.rec.arrival} <= ctl.now;
	// Lower priority number wins, then earlier arrival; equal keeps earlier load order.
	assign better = !has_q || (ctl.rec.prio < best_q.prio) ||
		((ctl.rec.prio == best_q.prio) && (ctl.rec.arrival < best_q.arrival));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_q  <= 1'b0;
			idx_q  <= '0;
			best_q <= '0;
			next_q <= '1;
		end else if (ctl.start) begin
			has_q  <= 1'b0;
			next_q <= '1;
		end else if (ctl.vld && !ctl.fin) begin
			if (ready_now) begin
				if (better) begin
					has_q  <= 1'b1;
					idx_q  <= ctl.idx;
					best_q <= ctl.rec;
				end
			end else if (ctl.rec.arrival < next_q) begin
				next_q <= ctl.rec.arrival;
			end
		end
	end

	assign st.has_pick = has_q;
	assign st.pick_idx = idx_q;
	assign st.pick     = best_q;
	assign st.next_arr = next_q;

endmodule
`default_nettype wire

### sv/nonpreemptive_priority_scheduler.sv
// Top level: record memory, scheduling sequencer and result register.
//
//  channel | dir | transaction
//  rec     | in  | one process record, last_record starts the pass
//  res     | out | one completed process with running totals
//
// Records load in one cycle each while the block is in its load phase.
// Each scheduling decision scans the record memory, one read per cycle,
// then steps through the arithmetic states CALC1 to CALC4 and waits in the
// emit state until the result is handed over. An idle gap costs one extra scan.
// Reset clears control state only; the memory is not cleared.
`default_nettype none
`include "assert_macros.svh"
module nonpreemptive_priority_scheduler #(
	parameter int MAX_PROCS = 16
) (
	input wire        clk,
	input wire        arst_n,
	nps_rec_if.sink   rec,
	nps_res_if.source res
);

	localparam int AW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int CW = $clog2(MAX_PROCS + 1);

	typedef enum logic [2:0] {
		ST_LOAD, ST_SCAN, ST_CALC1, ST_CALC2, ST_CALC3, ST_CALC4, ST_EMIT
	} state_t;

	state_t                          state_q;
	logic [CW-1:0]                   cnt_q;
	logic [CW-1:0]                   iss_q;
	logic [CW-1:0]                   done_q;
	logic                            start_q;
	logic                            vld_s1;
	logic [nps_pkg::ID_W-1:0]        idx_s1;
	nps_pkg::rec_t                   rd_s1;
	nps_pkg::rec_t                   mem_q [MAX_PROCS];
	logic [MAX_PROCS-1:0]            fin_q;
	logic [nps_pkg::TIME_W-1:0]      time_q;
	logic [nps_pkg::SUM_W-1:0]       sum_t_q;
	logic [nps_pkg::SUM_W-1:0]       sum_w_q;
	logic [nps_pkg::TIME_W-1:0]      comp_q;
	logic [nps_pkg::TIME_W-1:0]      tat_q;
	logic [nps_pkg::TIME_W-1:0]      wt_q;

	logic                            out_vld_q;
	logic [nps_pkg::ID_W-1:0]        out_id_q;
	logic [nps_pkg::TIME_W-1:0]      out_comp_q;
	logic [nps_pkg::TIME_W-1:0]      out_tat_q;
	logic [nps_pkg::TIME_W-1:0]      out_wt_q;
	logic [nps_pkg::SUM_W-1:0]       out_tt_q;
	logic [nps_pkg::SUM_W-1:0]       out_tw_q;
	logic                            out_last_q;

	logic                            rec_fire;
	logic                            res_fire;
	logic                            has_room;
	logic                            rd_en;
	logic                            scan_end;
	logic                            start_nxt;
	nps_pkg::scan_ctl_t              sctl;
	nps_pkg::scan_st_t               sst;
	logic [nps_pkg::TIME_W:0]        comp_sum;
	logic [nps_pkg::TIME_W-1:0]      burst_x;
	logic [nps_pkg::SUM_W:0]         tsum;
	logic [nps_pkg::SUM_W:0]         wsum;
	logic                            times_ok;
	logic                            batch_clear;

	assign rec.ready = (state_q == ST_LOAD);
	assign rec_fire  = rec.valid && rec.ready;
	assign res_fire  = res.valid && res.ready;
	assign has_room  = (cnt_q < CW'(MAX_PROCS));
	assign rd_en     = (state_q == ST_SCAN) && (iss_q < cnt_q);
	assign scan_end  = (state_q == ST_SCAN) && (iss_q == cnt_q) && !vld_s1;
	// Start a scan after the final record, after an idle jump, or after a handed-over result.
	assign start_nxt = (rec_fire && rec.last_record) ||
		(scan_end && !sst.has_pick) ||
		((state_q == ST_EMIT) && res_fire && !out_last_q);

	// Record memory: one write port for loading, one registered read port for scans.
	always_ff @(posedge clk) begin
		if (rec_fire && has_room)
			mem_q[cnt_q[AW-1:0]] <= '{arrival: rec.arrival_time, burst: rec.burst_time,
				prio: rec.priority_level};
		if (rd_en)
			rd_s1 <= mem_q[iss_q[AW-1:0]];
	end

	assign sctl.start = start_q;
	assign sctl.vld   = vld_s1;
	assign sctl.fin   = fin_q[idx_s1[AW-1:0]];
	assign sctl.idx   = idx_s1;
	assign sctl.rec   = rd_s1;
	assign sctl.now   = time_q;

	nps_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (sctl),
		.st     (sst)
	);

	assign burst_x  = {{(nps_pkg::TIME_W-nps_pkg::BURST_W){1'b0}}, sst.pick.burst};
	assign comp_sum = {1'b0, time_q} + {1'b0, burst_x};
	assign tsum     = {1'b0, sum_t_q} + {{(nps_pkg::SUM_W-nps_pkg::TIME_W+1){1'b0}}, tat_q};
	assign wsum     = {1'b0, sum_w_q} + {{(nps_pkg::SUM_W-nps_pkg::TIME_W+1){1'b0}}, wt_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			cnt_q      <= '0;
			iss_q      <= '0;
			done_q     <= '0;
			start_q    <= 1'b0;
			vld_s1     <= 1'b0;
			idx_s1     <= '0;
			fin_q      <= '0;
			time_q     <= '0;
			sum_t_q    <= '0;
			sum_w_q    <= '0;
			comp_q     <= '0;
			tat_q      <= '0;
			wt_q       <= '0;
			out_vld_q  <= 1'b0;
			out_id_q   <= '0;
			out_comp_q <= '0;
			out_tat_q  <= '0;
			out_wt_q   <= '0;
			out_tt_q   <= '0;
			out_tw_q   <= '0;
			out_last_q <= 1'b0;
		end else begin
			start_q <= start_nxt;
			vld_s1  <= rd_en;
			idx_s1  <= nps_pkg::ID_W'(iss_q);
			case (state_q)
				ST_LOAD: begin
					if (rec_fire) begin
						// drop the record when the store is full
						if (has_room)
							cnt_q <= cnt_q + 1'b1;
						if (rec.last_record) begin
							state_q <= ST_SCAN;
							iss_q   <= '0;
							time_q  <= '0;
						end
					end
				end
				ST_SCAN: begin
					if (rd_en)
						iss_q <= iss_q + 1'b1;
					if (scan_end) begin
						if (sst.has_pick) begin
							state_q <= ST_CALC1;
						end else begin
							// idle processor: jump to the next arrival and rescan
							time_q  <= {{(nps_pkg::TIME_W-nps_pkg::ARR_W){1'b0}},
								sst.next_arr};
							iss_q   <= '0;
						end
					end
				end
				ST_CALC1: begin
					comp_q  <= comp_sum[nps_pkg::TIME_W] ? nps_pkg::TIME_MAX :
						comp_sum[nps_pkg::TIME_W-1:0];
					state_q <= ST_CALC2;
				end
				ST_CALC2: begin
					tat_q  <= comp_q - {{(nps_pkg::TIME_W-nps_pkg::ARR_W){1'b0}},
						sst.pick.arrival};
					time_q <= comp_q;
					fin_q[sst.pick_idx[AW-1:0]] <= 1'b1;
					state_q <= ST_CALC3;
				end
				ST_CALC3: begin
					wt_q    <= (tat_q >= burst_x) ? tat_q - burst_x : '0;
					sum_t_q <= (tsum > {1'b0, nps_pkg::SUM_MAX}) ? nps_pkg::SUM_MAX :
						tsum[nps_pkg::SUM_W-1:0];
					state_q <= ST_CALC4;
				end
				ST_CALC4: begin
					sum_w_q    <= (wsum > {1'b0, nps_pkg::SUM_MAX}) ? nps_pkg::SUM_MAX :
						wsum[nps_pkg::SUM_W-1:0];
					out_tw_q   <= (wsum > {1'b0, nps_pkg::SUM_MAX}) ? nps_pkg::SUM_MAX :
						wsum[nps_pkg::SUM_W-1:0];
					out_tt_q   <= sum_t_q;
					out_id_q   <= sst.pick_idx;
					out_comp_q <= comp_q;
					out_tat_q  <= tat_q;
					out_wt_q   <= wt_q;
					out_last_q <= (CW'(done_q + 1'b1) == cnt_q);
					out_vld_q  <= 1'b1;
					state_q    <= ST_EMIT;
				end
				ST_EMIT: begin
					if (res_fire) begin
						out_vld_q <= 1'b0;
						if (out_last_q) begin
							// end of pass: clear the batch
							state_q <= ST_LOAD;
							cnt_q   <= '0;
							done_q  <= '0;
							fin_q   <= '0;
							time_q  <= '0;
							sum_t_q <= '0;
							sum_w_q <= '0;
						end else begin
							state_q <= ST_SCAN;
							done_q  <= done_q + 1'b1;
							iss_q   <= '0;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	assign res.valid            = out_vld_q;
	assign res.process_id       = out_id_q;
	assign res.completion_time  = out_comp_q;
	assign res.turnaround_time  = out_tat_q;
	assign res.waiting_time     = out_wt_q;
	assign res.total_turnaround = out_tt_q;
	assign res.total_waiting    = out_tw_q;
	assign res.last_result      = out_last_q;

	assign times_ok    = (res.waiting_time <= res.turnaround_time) &&
		(res.turnaround_time <= res.completion_time);
	assign batch_clear = (cnt_q == '0) && (fin_q == '0) && rec.ready;

	`NPS_ASSERT(a_load_excl_emit, !(rec.ready && res.valid), "record taken while result pending")
	`NPS_ASSERT(a_cnt_bound, cnt_q <= CW'(MAX_PROCS), "record count beyond store depth")
	`NPS_ASSERT(a_time_order, !res.valid || times_ok, "result times out of order")
	`NPS_ASSERT_NEXT(a_pass_clear, res_fire && res.last_result, batch_clear, "batch not cleared")

endmodule
`default_nettype wire
